// ===== rtl/core/fpa_pkg.sv =====
// Shared types and constants for the fixed-point ALU.
// Holds the command codes, field widths and the pipeline control record.
// No dependencies.
package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 4;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_GT,
    CMD_LT,
    CMD_GE,
    CMD_LE,
    CMD_EQ,
    CMD_NE,
    CMD_MIN,
    CMD_MAX,
    CMD_INC,
    CMD_DEC,
    CMD_FROM_INT,
    CMD_TO_INT
  } cmd_t;

  // Per-stage control carried alongside the divider datapath
  typedef struct packed {
    logic              is_div;
    logic              neg;
    logic              dz;
    logic              cmp;
    logic [DATA_W-1:0] val;
  } ctl_t;

endpackage

// ===== rtl/core/fpa_req_if.sv =====
// Request channel of the fixed-point ALU: valid/ready plus command and operands.
// Depends on fpa_pkg.
interface fpa_req_if;
  import fpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;

  modport source (output valid, output command, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input command, input operand_a, input operand_b,
                  output ready);
endinterface

// ===== rtl/core/fpa_rsp_if.sv =====
// Result channel of the fixed-point ALU: valid/ready plus value and flags.
// Depends on fpa_pkg.
interface fpa_rsp_if;
  import fpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     compare_true;
  logic                     divide_by_zero;

  modport source (output valid, output value, output compare_true, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input value, input compare_true, input divide_by_zero,
                  output ready);
endinterface

// ===== rtl/core/fixed_point_alu_unit.sv =====
// Pipelined signed fixed-point ALU, Q(32-F).F, top level.
// Depends on fpa_pkg, fpa_req_if and fpa_rsp_if.
//
// Usage:
//   request carries a command and two raw 32-bit operands; result carries
//   the raw value plus compare_true and divide_by_zero. Both channels move
//   an item on a rising clk edge where valid and ready are both high.
//   Every command returns exactly one result item, in request order.
// Pipeline: every command passes through the same stages; the depth is set
//   by the divider, which resolves one quotient bit per stage over
//   32 + FRAC_BITS stages.
// Throughput: one item per cycle while result.ready is high.
// Stall: each stage moves when the next one is empty or moving, so bubbles
//   close up and request.ready stays high while any stage is empty, even
//   with a result waiting at the output.
// Reset: rst (synchronous, active high) clears all stage valid bits; items
//   in flight are dropped.
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  fpa_req_if.sink  request,
  fpa_rsp_if.source result
);
  import fpa_pkg::*;

  localparam int DivW   = DATA_W + FRAC_BITS;  // dividend bits, one stage each
  localparam int NumStg = DivW + 3;            // input, setup, divider, output

  logic [NumStg-1:0] vld;
  logic [NumStg:0]   adv;

  // Stage 0: registered request
  cmd_t                     cmd0;
  logic signed [DATA_W-1:0] a0;
  logic signed [DATA_W-1:0] b0;

  // Stage 1 inputs
  logic signed [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]          abs_a;
  logic [DATA_W-1:0]          abs_b;
  ctl_t                       ctl1;

  // Divider stages
  ctl_t              ctl [1:DivW+1];
  logic [DATA_W-1:0] rem [1:DivW+1];
  logic [DATA_W-1:0] quo [1:DivW+1];
  logic [DATA_W-1:0] den [1:DivW+1];
  logic [DivW-1:0]   num [1:DivW+1];

  // Output stage
  logic [DATA_W-1:0] out_val;
  logic              out_cmp;
  logic              out_dz;
  logic [DATA_W-1:0] quo_fix;

  // Advance each stage when it is empty or the next stage advances
  assign adv[NumStg] = result.ready;
  for (genvar g = 0; g < NumStg; g++) begin : g_adv
    assign adv[g] = !vld[g] || adv[g+1];
  end

  assign request.ready = adv[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= request.valid;
      end
      for (int i = 1; i < NumStg; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cmd0 <= cmd_t'(request.command);
      a0   <= request.operand_a;
      b0   <= request.operand_b;
    end
  end

  // Decode, simple operations, multiply and divider setup
  assign abs_a = a0[DATA_W-1] ? -a0 : a0;
  assign abs_b = b0[DATA_W-1] ? -b0 : b0;

  always_comb begin
    prod     = (2*DATA_W)'(a0) * (2*DATA_W)'(b0);
    ctl1     = '0;
    ctl1.neg = a0[DATA_W-1] ^ b0[DATA_W-1];
    case (cmd0)
      CMD_ADD:      ctl1.val = a0 + b0;
      CMD_SUB:      ctl1.val = a0 - b0;
      CMD_MUL:      ctl1.val = prod[FRAC_BITS +: DATA_W];
      CMD_DIV: begin
        ctl1.is_div = 1'b1;
        ctl1.dz     = (b0 == '0);
      end
      CMD_GT:       ctl1.cmp = (a0 > b0);
      CMD_LT:       ctl1.cmp = (a0 < b0);
      CMD_GE:       ctl1.cmp = (a0 >= b0);
      CMD_LE:       ctl1.cmp = (a0 <= b0);
      CMD_EQ:       ctl1.cmp = (a0 == b0);
      CMD_NE:       ctl1.cmp = (a0 != b0);
      CMD_MIN:      ctl1.val = (a0 < b0) ? a0 : b0;
      CMD_MAX:      ctl1.val = (a0 > b0) ? a0 : b0;
      CMD_INC:      ctl1.val = a0 + DATA_W'(1);
      CMD_DEC:      ctl1.val = a0 - DATA_W'(1);
      CMD_FROM_INT: ctl1.val = a0 <<< FRAC_BITS;
      CMD_TO_INT:   ctl1.val = a0 >>> FRAC_BITS;
      default:      ctl1.val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ctl[1] <= ctl1;
      rem[1] <= '0;
      quo[1] <= '0;
      den[1] <= abs_b;
      num[1] <= {abs_a, {FRAC_BITS{1'b0}}};
    end
  end

  // Restoring divide on magnitudes, one quotient bit per stage
  for (genvar k = 0; k < DivW; k++) begin : g_div
    logic [DATA_W:0] shf;
    logic [DATA_W:0] dif;
    logic            ge;

    always_comb begin
      shf = {rem[k+1], num[k+1][DivW-1]};
      dif = shf - {1'b0, den[k+1]};
      ge  = (shf >= {1'b0, den[k+1]});
    end

    always_ff @(posedge clk) begin
      if (adv[k+2]) begin
        ctl[k+2] <= ctl[k+1];
        den[k+2] <= den[k+1];
        num[k+2] <= num[k+1] << 1;
        quo[k+2] <= {quo[k+1][DATA_W-2:0], ge};
        rem[k+2] <= ge ? dif[DATA_W-1:0] : shf[DATA_W-1:0];
      end
    end
  end

  // Apply the quotient sign and select the final value
  assign quo_fix = ctl[DivW+1].neg ? -quo[DivW+1] : quo[DivW+1];

  always_ff @(posedge clk) begin
    if (adv[NumStg-1]) begin
      out_cmp <= ctl[DivW+1].cmp;
      out_dz  <= ctl[DivW+1].dz;
      if (ctl[DivW+1].is_div) begin
        out_val <= ctl[DivW+1].dz ? '0 : quo_fix;
      end else begin
        out_val <= ctl[DivW+1].val;
      end
    end
  end

  assign result.valid          = vld[NumStg-1];
  assign result.value          = out_val;
  assign result.compare_true   = out_cmp;
  assign result.divide_by_zero = out_dz;

  // A divide-by-zero result is zero and never a comparison
  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_by_zero |-> result.value == '0 && !result.compare_true)
    else $error("divide_by_zero result carries a nonzero value or compare flag");

  // A comparison result carries a zero value
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.compare_true |-> result.value == '0)
    else $error("comparison result carries a nonzero value");

  // An accepted request occupies the first stage on the next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> vld[0])
    else $error("accepted request did not enter the pipeline");

endmodule
